// ----- hdl/dtf_pkg.sv -----
// domino tiling flip engine: shared types and codes
// cell, action and flip result codes, controller command and status structs
// no dependencies
package dtf_pkg;

	localparam int ACT_W  = 2;
	localparam int COORD_W = 9;
	localparam int CELL_W = 3;
	localparam int FLIP_W = 2;

	typedef logic [CELL_W-1:0] cell_t;
	typedef logic [ACT_W-1:0]  action_t;
	typedef logic [FLIP_W-1:0] flip_t;

	localparam cell_t CELL_EMPTY = 3'd0;
	localparam cell_t CELL_V1    = 3'd1;
	localparam cell_t CELL_V2    = 3'd2;
	localparam cell_t CELL_H1    = 3'd3;
	localparam cell_t CELL_H2    = 3'd4;

	localparam action_t ACT_WRITE = 2'd0;
	localparam action_t ACT_READ  = 2'd1;
	localparam action_t ACT_FLIP  = 2'd2;

	localparam flip_t FLIP_NONE = 2'd0;
	localparam flip_t FLIP_H2V  = 2'd1;
	localparam flip_t FLIP_V2H  = 2'd2;
	localparam flip_t FLIP_OOR  = 2'd3;

	typedef struct packed {
		logic clear_wr;
		logic accept;
		logic exec;
	} ctl_cmd_t;

	typedef struct packed {
		logic clear_last;
	} ctl_sts_t;

endpackage

// ----- hdl/dtf_controller.sv -----
// domino tiling flip engine: controller state machine
// sequences the clearing pass, accept and execute cycles; uses dtf_pkg
module dtf_controller (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output dtf_pkg::ctl_cmd_t cmd,
	input  dtf_pkg::ctl_sts_t sts
);
	import dtf_pkg::*;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_EXEC  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sts.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign cmd.clear_wr = (state_q == ST_CLEAR);
	assign cmd.accept   = (state_q == ST_IDLE) && start;
	assign cmd.exec     = (state_q == ST_EXEC);

endmodule

// ----- hdl/dtf_datapath.sv -----
// domino tiling flip engine: datapath with four parity banks of the grid
// address generation, pattern match, write back and result registers; uses dtf_pkg
module dtf_datapath #(
	parameter int GRID_SIDE = 512
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dtf_pkg::ctl_cmd_t           cmd,
	output dtf_pkg::ctl_sts_t           sts,
	input  logic [dtf_pkg::ACT_W-1:0]   action,
	input  logic [dtf_pkg::COORD_W-1:0] col,
	input  logic [dtf_pkg::COORD_W-1:0] row,
	input  logic [dtf_pkg::CELL_W-1:0]  cell_code,
	output logic [dtf_pkg::CELL_W-1:0]  read_value,
	output logic [dtf_pkg::FLIP_W-1:0]  flip_result,
	output logic                        done
);
	import dtf_pkg::*;

	localparam int CW    = $clog2(GRID_SIDE);
	localparam int HW    = CW - 1;
	localparam int AW    = 2 * HW;
	localparam int DEPTH = 1 << AW;

	logic [CW-1:0] xc, yc, xp1, yp1;
	logic          rw_ok, flip_ok;
	cell_t         code_clamped;

	// operation held from accept to execute
	action_t act_q;
	logic    x0_q, y0_q;
	logic    rw_ok_q, flip_ok_q;
	cell_t   code_q;

	logic [AW-1:0] clr_cnt_q;

	cell_t         rdata_q [4];
	logic [AW-1:0] addr_q  [4];
	logic [3:0]    wr_en;
	cell_t         wr_data [4];

	logic  odd, h2v, v2h, do_flip;
	cell_t c00, c10, c01, c11;
	cell_t top_c, bot_c, lft_c, rgt_c;
	cell_t rd_d;
	flip_t fr_d;

	cell_t read_value_q;
	flip_t flip_result_q;
	logic  done_q;

	assign xc  = CW'(col);
	assign yc  = CW'(row);
	assign xp1 = xc + CW'(1);
	assign yp1 = yc + CW'(1);

	assign rw_ok   = (32'(col) < GRID_SIDE) && (32'(row) < GRID_SIDE);
	assign flip_ok = (32'(col) <= GRID_SIDE - 2) && (32'(row) <= GRID_SIDE - 2);
	assign code_clamped = (cell_code <= CELL_H2) ? cell_code : CELL_EMPTY;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			act_q     <= action;
			x0_q      <= xc[0];
			y0_q      <= yc[0];
			rw_ok_q   <= rw_ok;
			flip_ok_q <= flip_ok;
			code_q    <= code_clamped;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clear_wr) begin
			clr_cnt_q <= clr_cnt_q + AW'(1);
		end
	end

	assign sts.clear_last = (clr_cnt_q == '1);

	// bank index is {row parity, column parity}
	assign odd   = x0_q ^ y0_q;
	assign top_c = odd ? CELL_H1 : CELL_H2;
	assign bot_c = odd ? CELL_H2 : CELL_H1;
	assign lft_c = odd ? CELL_V1 : CELL_V2;
	assign rgt_c = odd ? CELL_V2 : CELL_V1;

	assign c00 = rdata_q[{y0_q, x0_q}];
	assign c10 = rdata_q[{y0_q, ~x0_q}];
	assign c01 = rdata_q[{~y0_q, x0_q}];
	assign c11 = rdata_q[{~y0_q, ~x0_q}];

	assign h2v = (c00 == top_c) && (c10 == top_c) && (c01 == bot_c) && (c11 == bot_c);
	assign v2h = !h2v && (c00 == lft_c) && (c01 == lft_c) && (c10 == rgt_c)
		&& (c11 == rgt_c);
	assign do_flip = (act_q == ACT_FLIP) && flip_ok_q && (h2v || v2h);

	for (genvar b = 0; b < 4; b++) begin : g_bank
		localparam logic BX = 1'(b % 2);
		localparam logic BY = 1'(b / 2);

		logic [CW-1:0] cx, cy;
		logic [AW-1:0] raddr, waddr;
		logic          is_left, is_top, wen;
		cell_t         wdata;
		cell_t         mem [DEPTH];

		assign cx    = (xc[0] == BX) ? xc : xp1;
		assign cy    = (yc[0] == BY) ? yc : yp1;
		assign raddr = {cy[CW-1:1], cx[CW-1:1]};

		assign is_left = (x0_q == BX);
		assign is_top  = (y0_q == BY);

		always_comb begin
			wr_en[b]   = 1'b0;
			wr_data[b] = code_q;
			case (act_q)
				ACT_WRITE: begin
					wr_en[b]   = rw_ok_q && (x0_q == BX) && (y0_q == BY);
					wr_data[b] = code_q;
				end
				ACT_FLIP: begin
					wr_en[b]   = do_flip;
					wr_data[b] = h2v ? (is_left ? lft_c : rgt_c) : (is_top ? top_c : bot_c);
				end
				default: begin
					wr_en[b] = 1'b0;
				end
			endcase
		end

		assign wen   = cmd.clear_wr || (cmd.exec && wr_en[b]);
		assign waddr = cmd.clear_wr ? clr_cnt_q : addr_q[b];
		assign wdata = cmd.clear_wr ? CELL_EMPTY : wr_data[b];

		always_ff @(posedge clk) begin
			if (wen) begin
				mem[waddr] <= wdata;
			end
		end

		always_ff @(posedge clk) begin
			if (cmd.accept) begin
				rdata_q[b] <= mem[raddr];
				addr_q[b]  <= raddr;
			end
		end
	end

	always_comb begin
		rd_d = CELL_EMPTY;
		fr_d = FLIP_NONE;
		case (act_q)
			ACT_WRITE: begin
				fr_d = rw_ok_q ? FLIP_NONE : FLIP_OOR;
			end
			ACT_READ: begin
				rd_d = rw_ok_q ? c00 : CELL_EMPTY;
				fr_d = rw_ok_q ? FLIP_NONE : FLIP_OOR;
			end
			ACT_FLIP: begin
				if (!flip_ok_q) begin
					fr_d = FLIP_OOR;
				end else if (h2v) begin
					fr_d = FLIP_H2V;
				end else if (v2h) begin
					fr_d = FLIP_V2H;
				end else begin
					fr_d = FLIP_NONE;
				end
			end
			default: begin
				fr_d = FLIP_NONE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			read_value_q  <= rd_d;
			flip_result_q <= fr_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.exec;
		end
	end

	assign read_value  = read_value_q;
	assign flip_result = flip_result_q;
	assign done        = done_q;

endmodule

// ----- hdl/domino_tiling_flip_engine_top.sv -----
// Domino tiling flip engine. A command is taken when start is high and busy is low;
// each command gives exactly one result, shown on read_value and flip_result for the
// single cycle in which done is high, which is the cycle after the command's execute cycle. The
// receiver cannot stall. For every command (write, read or flip) the grid
// cells are read from four parity banks at the accept edge; writes and flips
// write back in the execute cycle, in which busy is high for one cycle, so no new command
// is taken then. After reset the grid is cleared one address of all four banks per cycle,
// through all 2**(2*($clog2(GRID_SIDE)-1)) addresses (65536 at GRID_SIDE 512), with busy held high.
// top level: joins dtf_controller and dtf_datapath; uses dtf_pkg
module domino_tiling_flip_engine_top #(
	parameter int GRID_SIDE = 512
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [dtf_pkg::ACT_W-1:0]   action,
	input  logic [dtf_pkg::COORD_W-1:0] col,
	input  logic [dtf_pkg::COORD_W-1:0] row,
	input  logic [dtf_pkg::CELL_W-1:0]  cell_code,
	output logic [dtf_pkg::CELL_W-1:0]  read_value,
	output logic [dtf_pkg::FLIP_W-1:0]  flip_result,
	output logic                        done
);
	import dtf_pkg::*;

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	dtf_controller u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.sts    (sts)
	);

	dtf_datapath #(
		.GRID_SIDE (GRID_SIDE)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.action      (action),
		.col         (col),
		.row         (row),
		.cell_code   (cell_code),
		.read_value  (read_value),
		.flip_result (flip_result),
		.done        (done)
	);

	// a result follows every accepted transaction, through the execute state and then the done register
	a_done_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 done)
		else $error("result missing after accepted transaction");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after accepted transaction");

	a_done_only_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) && !busy))
		else $error("result strobe without execute cycle");

	a_fields_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((read_value == CELL_EMPTY) || (flip_result == FLIP_NONE)))
		else $error("read value and flip result both set");

endmodule
